FILE: hw/rtl/ctm_pkg.sv
// Package for the callback timing monitor: sequencer states, register indexes
// and the fixed constants of the datapath. No dependencies.
package ctm_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ELAP,
    ST_BUDGET,
    ST_SAMPLE,
    ST_ACCUM,
    ST_MAX,
    ST_OVERRUN,
    ST_DELAY,
    ST_CENTI,
    ST_CMUL,
    ST_DIV,
    ST_LAT,
    ST_FIN
  } ctm_state_e;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SPACING = 8'd1;

  localparam logic [19:0] FP_RESET      = 20'd20833;
  localparam logic [31:0] SPACING_RESET = 32'd10000000;

  localparam logic [13:0] CENTI_FULL  = 14'd10000;
  localparam logic [19:0] CENTI_SCALE = 20'd10000;
  localparam logic [35:0] NS_PER_US   = 36'd1000;
  localparam logic [15:0] LAT_MAX     = 16'hFFFF;
  // Elapsed times at or above this give a latency past the 16-bit range.
  localparam logic [63:0] LAT_SAT_NS  = 64'd65536000;

  localparam logic [3:0] DIV_LAST = 4'd15;

endpackage

FILE: hw/rtl/callback_timing_monitor_unit.sv
// Callback timing monitor: sequencer, shared multiplier and restoring divider.
// Depends on ctm_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one processing period per
//   transaction: start/end timestamps, frame count, interval deviation and
//   interval peak. Output channel (out_valid_o / out_stall_i) returns one
//   result per period: elapsed time, budget, running sum, maximum, overrun
//   count and, on a sample, budget use, latency and the delay flag.
//   Configuration (cfg_valid_i / cfg_ready_o) writes frame_period_ns at index
//   0 and sample_spacing_ns at index 1; it is always ready.
//   The sequencer steps one wide compare or add per cycle; on a sample it
//   also runs up to two 16-step passes of the shared one-bit-per-cycle
//   divider (budget use, then latency).
//   One period is worked on at a time; in_stall_o is high while it runs, so a
//   new transaction is taken only after the last result has left the sequencer.
//   A finished result sits in the output register, so the next transaction
//   is accepted while the receiver stalls; the sequencer holds in its final
//   state only if a second result is ready before the first is taken.
//   Reset clears the sum, maximum, overrun count, last sample time and
//   restores the configuration defaults.
module callback_timing_monitor_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [63:0]                   start_time_ns_i,
  input  logic [63:0]                   end_time_ns_i,
  input  logic [15:0]                   frames_i,
  input  logic                          interval_known_i,
  input  logic signed [63:0]            interval_deviation_ns_i,
  input  logic [31:0]                   interval_peak_ns_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          sample_valid_o,
  output logic [13:0]                   budget_centipct_o,
  output logic [15:0]                   latency_us_o,
  output logic [31:0]                   sampled_peak_ns_o,
  output logic                          delay_event_o,
  output logic                          overrun_event_o,
  output logic [63:0]                   elapsed_ns_o,
  output logic [35:0]                   budget_out_ns_o,
  output logic [63:0]                   total_time_ns_o,
  output logic [63:0]                   worst_time_ns_o,
  output logic [31:0]                   overrun_total_o,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ctm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  ctm_pkg::ctm_state_e state_q, state_d;

  // configuration
  logic [19:0] fp_q;
  logic [31:0] spacing_q;

  // persistent statistics
  logic [63:0] last_q;
  logic [63:0] sum_q;
  logic [63:0] max_q;
  logic [31:0] cnt_q;

  // latched transaction
  logic [63:0] start_q;
  logic [63:0] end_q;
  logic [15:0] frames_q;
  logic        known_q;
  logic [63:0] dev_q;
  logic [31:0] peak_q;

  // working values
  logic [63:0] elapsed_q;
  logic [35:0] budget_q;
  logic        sample_q;
  logic        over_q;
  logic        delay_q;
  logic [13:0] centi_q;
  logic [15:0] lat_q;

  // divider
  logic [35:0] rem_q;
  logic [15:0] num_lo_q;
  logic [35:0] den_q;
  logic [15:0] quot_q;
  logic [3:0]  cnt_div_q;
  logic        div_lat_q;

  // output register
  logic        out_valid_q;
  logic        o_sample_q;
  logic [13:0] o_centi_q;
  logic [15:0] o_lat_q;
  logic [31:0] o_peak_q;
  logic        o_delay_q;
  logic        o_over_q;
  logic [63:0] o_elapsed_q;
  logic [35:0] o_budget_q;
  logic [63:0] o_sum_q;
  logic [63:0] o_max_q;
  logic [31:0] o_cnt_q;

  logic        in_accept;
  logic        out_load;
  logic        cfg_write;

  // shared multiplier
  logic [35:0] mul_a;
  logic [19:0] mul_b;
  logic [55:0] mul_p;

  // divider step
  logic [36:0] trial;
  logic        trial_ge;
  logic [36:0] trial_sub;
  logic [35:0] rem_nxt;
  logic [15:0] quot_nxt;

  // compare results
  logic sample_hit;
  logic elapsed_gt_max;
  logic overrun_hit;
  logic delay_hit;
  logic elapsed_ge_budget;
  logic lat_saturate;

  assign in_accept   = in_valid_i && (state_q == ctm_pkg::ST_IDLE);
  assign in_stall_o  = (state_q != ctm_pkg::ST_IDLE);
  assign out_load    = (state_q == ctm_pkg::ST_FIN) && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i;

  assign mul_a = (state_q == ctm_pkg::ST_CMUL) ? elapsed_q[35:0] : {20'b0, frames_q};
  assign mul_b = (state_q == ctm_pkg::ST_CMUL) ? ctm_pkg::CENTI_SCALE : fp_q;
  assign mul_p = mul_a * mul_b;

  assign trial     = {rem_q, num_lo_q[15]};
  assign trial_ge  = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};
  assign rem_nxt   = trial_ge ? trial_sub[35:0] : trial[35:0];
  assign quot_nxt  = {quot_q[14:0], trial_ge};

  assign sample_hit        = (start_q - last_q) >= {32'b0, spacing_q};
  assign elapsed_gt_max    = elapsed_q > max_q;
  assign overrun_hit       = elapsed_q > {29'b0, budget_q[35:1]};
  assign delay_hit         = known_q && !dev_q[63] && (dev_q > {27'b0, budget_q, 1'b0});
  assign elapsed_ge_budget = elapsed_q >= {28'b0, budget_q};
  assign lat_saturate      = elapsed_q >= ctm_pkg::LAT_SAT_NS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ctm_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ctm_pkg::ST_ELAP;
      end
      ctm_pkg::ST_ELAP:    state_d = ctm_pkg::ST_BUDGET;
      ctm_pkg::ST_BUDGET:  state_d = ctm_pkg::ST_SAMPLE;
      ctm_pkg::ST_SAMPLE:  state_d = ctm_pkg::ST_ACCUM;
      ctm_pkg::ST_ACCUM:   state_d = ctm_pkg::ST_MAX;
      ctm_pkg::ST_MAX:     state_d = ctm_pkg::ST_OVERRUN;
      ctm_pkg::ST_OVERRUN: begin
        state_d = sample_q ? ctm_pkg::ST_DELAY : ctm_pkg::ST_FIN;
      end
      ctm_pkg::ST_DELAY:   state_d = ctm_pkg::ST_CENTI;
      ctm_pkg::ST_CENTI: begin
        if (budget_q == '0 || elapsed_ge_budget) state_d = ctm_pkg::ST_LAT;
        else                                     state_d = ctm_pkg::ST_CMUL;
      end
      ctm_pkg::ST_CMUL:    state_d = ctm_pkg::ST_DIV;
      ctm_pkg::ST_DIV: begin
        if (cnt_div_q == ctm_pkg::DIV_LAST) begin
          state_d = div_lat_q ? ctm_pkg::ST_FIN : ctm_pkg::ST_LAT;
        end
      end
      ctm_pkg::ST_LAT: begin
        state_d = lat_saturate ? ctm_pkg::ST_FIN : ctm_pkg::ST_DIV;
      end
      ctm_pkg::ST_FIN: begin
        if (out_load) state_d = ctm_pkg::ST_IDLE;
      end
      default: state_d = ctm_pkg::ST_IDLE;
    endcase
  end

  // configuration, statistics and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q        <= ctm_pkg::FP_RESET;
      spacing_q   <= ctm_pkg::SPACING_RESET;
      last_q      <= '0;
      sum_q       <= '0;
      max_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index_i)
          ctm_pkg::CFG_FRAME_PERIOD:   fp_q      <= cfg_data_i[19:0];
          ctm_pkg::CFG_SAMPLE_SPACING: spacing_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ctm_pkg::ST_SAMPLE && sample_hit) last_q <= start_q;
      if (state_q == ctm_pkg::ST_ACCUM) sum_q <= sum_q + elapsed_q;
      if (state_q == ctm_pkg::ST_MAX && elapsed_gt_max) max_q <= elapsed_q;
      if (state_q == ctm_pkg::ST_OVERRUN && overrun_hit) cnt_q <= cnt_q + 32'd1;
      if (out_load)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      ctm_pkg::ST_IDLE: begin
        if (in_accept) begin
          start_q  <= start_time_ns_i;
          end_q    <= end_time_ns_i;
          frames_q <= frames_i;
          known_q  <= interval_known_i;
          dev_q    <= interval_deviation_ns_i;
          peak_q   <= interval_peak_ns_i;
          centi_q  <= '0;
          lat_q    <= '0;
          delay_q  <= 1'b0;
        end
      end
      ctm_pkg::ST_ELAP:    elapsed_q <= end_q - start_q;
      ctm_pkg::ST_BUDGET:  budget_q  <= mul_p[35:0];
      ctm_pkg::ST_SAMPLE:  sample_q  <= sample_hit;
      ctm_pkg::ST_OVERRUN: over_q    <= overrun_hit;
      ctm_pkg::ST_DELAY:   delay_q   <= delay_hit;
      ctm_pkg::ST_CENTI: begin
        if (budget_q != '0 && elapsed_ge_budget) centi_q <= ctm_pkg::CENTI_FULL;
      end
      ctm_pkg::ST_CMUL: begin
        // numerator below budget * 10000, so the top 34 bits start below the divisor
        rem_q     <= {2'b0, mul_p[49:16]};
        num_lo_q  <= mul_p[15:0];
        den_q     <= budget_q;
        cnt_div_q <= '0;
        div_lat_q <= 1'b0;
      end
      ctm_pkg::ST_LAT: begin
        if (lat_saturate) begin
          lat_q <= ctm_pkg::LAT_MAX;
        end else begin
          rem_q     <= {26'b0, elapsed_q[25:16]};
          num_lo_q  <= elapsed_q[15:0];
          den_q     <= ctm_pkg::NS_PER_US;
          cnt_div_q <= '0;
          div_lat_q <= 1'b1;
        end
      end
      ctm_pkg::ST_DIV: begin
        rem_q     <= rem_nxt;
        num_lo_q  <= {num_lo_q[14:0], 1'b0};
        quot_q    <= quot_nxt;
        cnt_div_q <= cnt_div_q + 4'd1;
        if (cnt_div_q == ctm_pkg::DIV_LAST) begin
          if (div_lat_q) lat_q   <= quot_nxt;
          else           centi_q <= quot_nxt[13:0];
        end
      end
      default: ;
    endcase

    if (out_load) begin
      o_sample_q  <= sample_q;
      o_centi_q   <= centi_q;
      o_lat_q     <= lat_q;
      o_peak_q    <= sample_q ? peak_q : 32'b0;
      o_delay_q   <= delay_q;
      o_over_q    <= over_q;
      o_elapsed_q <= elapsed_q;
      o_budget_q  <= budget_q;
      o_sum_q     <= sum_q;
      o_max_q     <= max_q;
      o_cnt_q     <= cnt_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sample_valid_o    = o_sample_q;
  assign budget_centipct_o = o_centi_q;
  assign latency_us_o      = o_lat_q;
  assign sampled_peak_ns_o = o_peak_q;
  assign delay_event_o     = o_delay_q;
  assign overrun_event_o   = o_over_q;
  assign elapsed_ns_o      = o_elapsed_q;
  assign budget_out_ns_o   = o_budget_q;
  assign total_time_ns_o   = o_sum_q;
  assign worst_time_ns_o   = o_max_q;
  assign overrun_total_o   = o_cnt_q;

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ctm_pkg::ST_DIV) |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

  a_valid_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ctm_pkg::ST_FIN))
    else $error("result raised outside final state");

  a_centi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (o_centi_q <= ctm_pkg::CENTI_FULL))
    else $error("budget use above full scale");

  a_no_sample_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !o_sample_q) |->
      (o_centi_q == '0 && o_lat_q == '0 && o_delay_q == 1'b0 && o_peak_q == '0))
    else $error("sample fields set without a sample");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ctm_pkg::ST_DIV) |=> in_stall_o)
    else $error("input taken during division");
`endif

endmodule

FILE: tb/sv/testbench.sv
// Testbench for callback_timing_monitor_unit: a directed table followed by random
// processing periods, each result checked against a hand-written expectation or the
// in-bench timing predictor. Depends on ctm_pkg and the block's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] start_ns;
    logic [63:0] end_ns;
    logic [15:0] frames;
    logic        known;
    logic [63:0] dev_ns;
    logic [31:0] peak_ns;
  } period_t;

  typedef struct packed {
    logic        sample_valid;
    logic [13:0] budget_centipct;
    logic [15:0] latency_us;
    logic [31:0] sampled_peak_ns;
    logic        delay_event;
    logic        overrun_event;
    logic [63:0] span_ns;
    logic [35:0] budget_out_ns;
    logic [63:0] total_time_ns;
    logic [63:0] worst_time_ns;
    logic [31:0] overrun_total;
  } report_t;

  // ROW_CHECKED carries a hand-written expectation; ROW_PERIOD goes to the predictor.
  typedef enum logic [1:0] {ROW_PERIOD, ROW_CHECKED, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e                     kind;
    period_t                       period;
    report_t                       want;
    logic [ctm_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [31:0]                   reg_data;
  } row_t;

  localparam logic [ctm_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 8'd2;
  localparam logic [63:0] CENTI_SCALE  = 64'd10000;
  localparam logic [63:0] LATENCY_CAP  = 64'd65535;
  localparam logic [63:0] NS_IN_US     = 64'd1000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES  = 60;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 230;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [63:0]                   start_time_ns_i;
  logic [63:0]                   end_time_ns_i;
  logic [15:0]                   frames_i;
  logic                          interval_known_i;
  logic signed [63:0]            interval_deviation_ns_i;
  logic [31:0]                   interval_peak_ns_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic                          sample_valid_o;
  logic [13:0]                   budget_centipct_o;
  logic [15:0]                   latency_us_o;
  logic [31:0]                   sampled_peak_ns_o;
  logic                          delay_event_o;
  logic                          overrun_event_o;
  logic [63:0]                   elapsed_ns_o;
  logic [35:0]                   budget_out_ns_o;
  logic [63:0]                   total_time_ns_o;
  logic [63:0]                   worst_time_ns_o;
  logic [31:0]                   overrun_total_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [ctm_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]                   cfg_data_i;

  // Predictor copy of the configuration and the running statistics.
  logic [19:0] fp_ns_cfg;
  logic [31:0] spacing_ns_cfg;
  logic [63:0] last_sample_ns;
  logic [63:0] elapsed_sum_ns;
  logic [63:0] elapsed_max_ns;
  logic [31:0] overrun_count;
  logic [63:0] stream_ns;

  report_t     expected_reports[$];
  bit          failed;
  bit          quiet;

  callback_timing_monitor_unit dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .in_valid_i              (in_valid_i),
    .in_stall_o              (in_stall_o),
    .start_time_ns_i         (start_time_ns_i),
    .end_time_ns_i           (end_time_ns_i),
    .frames_i                (frames_i),
    .interval_known_i        (interval_known_i),
    .interval_deviation_ns_i (interval_deviation_ns_i),
    .interval_peak_ns_i      (interval_peak_ns_i),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .sample_valid_o          (sample_valid_o),
    .budget_centipct_o       (budget_centipct_o),
    .latency_us_o            (latency_us_o),
    .sampled_peak_ns_o       (sampled_peak_ns_o),
    .delay_event_o           (delay_event_o),
    .overrun_event_o         (overrun_event_o),
    .elapsed_ns_o            (elapsed_ns_o),
    .budget_out_ns_o         (budget_out_ns_o),
    .total_time_ns_o         (total_time_ns_o),
    .worst_time_ns_o         (worst_time_ns_o),
    .overrun_total_o         (overrun_total_o),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_ready_o             (cfg_ready_o),
    .cfg_index_i             (cfg_index_i),
    .cfg_data_i              (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("callback_timing_monitor_unit: mismatch");
    $finish;
  end

  function automatic report_t predict_period(input period_t p);
    report_t     r;
    logic [63:0] elapsed;
    logic [63:0] budget;
    logic [63:0] lat;
    r       = '0;
    elapsed = p.end_ns - p.start_ns;
    budget  = 64'(p.frames) * 64'(fp_ns_cfg);
    elapsed_sum_ns = elapsed_sum_ns + elapsed;
    if (p.start_ns - last_sample_ns >= 64'(spacing_ns_cfg)) begin
      r.sample_valid = 1'b1;
      if (budget != 0) begin
        // saturate by exact compare; below budget the product stays under 2^50
        r.budget_centipct = (elapsed >= budget) ? 14'(CENTI_SCALE)
                                                : 14'((elapsed * CENTI_SCALE) / budget);
      end
      lat = elapsed / NS_IN_US;
      r.latency_us      = (lat > LATENCY_CAP) ? 16'(LATENCY_CAP) : 16'(lat);
      r.sampled_peak_ns = p.peak_ns;
      last_sample_ns    = p.start_ns;
      r.delay_event     = p.known && !p.dev_ns[63] && (p.dev_ns > (budget << 1));
    end
    if (elapsed > elapsed_max_ns) elapsed_max_ns = elapsed;
    if (elapsed > (budget >> 1)) begin
      r.overrun_event = 1'b1;
      overrun_count   = overrun_count + 32'd1;
    end
    r.span_ns       = elapsed;
    r.budget_out_ns = 36'(budget);
    r.total_time_ns = elapsed_sum_ns;
    r.worst_time_ns = elapsed_max_ns;
    r.overrun_total = overrun_count;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic period_t period_of(input logic [63:0] start_ns, input logic [63:0] end_ns,
                                        input logic [15:0] frames, input logic known,
                                        input logic [63:0] dev_ns,
                                        input logic [31:0] peak_ns);
    period_t p;
    p.start_ns = start_ns;
    p.end_ns   = end_ns;
    p.frames   = frames;
    p.known    = known;
    p.dev_ns   = dev_ns;
    p.peak_ns  = peak_ns;
    return p;
  endfunction

  function automatic row_t item_row(input period_t p);
    row_t r;
    r        = '0;
    r.kind   = ROW_PERIOD;
    r.period = p;
    return r;
  endfunction

  function automatic row_t checked_row(input period_t p, input report_t want);
    row_t r;
    r        = '0;
    r.kind   = ROW_CHECKED;
    r.period = p;
    r.want   = want;
    return r;
  endfunction

  function automatic row_t reg_row(input logic [ctm_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [31:0] data);
    row_t r;
    r          = '0;
    r.kind     = ROW_REG;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  // Mostly a well-formed timeline near the sample boundary, some pure noise.
  function automatic period_t random_period();
    period_t     p;
    logic [63:0] budget;
    logic [63:0] elapsed;
    logic [63:0] step;
    int unsigned pick;
    p.known   = 1'($urandom_range(0, 1));
    p.peak_ns = $urandom;
    pick      = $urandom_range(0, 19);
    if (pick < 3) begin
      p.start_ns = {$urandom, $urandom};
      p.end_ns   = {$urandom, $urandom};
      p.frames   = 16'($urandom);
      p.dev_ns   = {$urandom, $urandom};
      return p;
    end
    case ($urandom_range(0, 9))
      0:       p.frames = '0;
      1:       p.frames = 16'hFFFF;
      default: p.frames = 16'($urandom_range(1, 2048));
    endcase
    budget = 64'(p.frames) * 64'(fp_ns_cfg);
    if (pick < 6) begin
      p.start_ns = last_sample_ns + 64'(spacing_ns_cfg) - 64'($urandom_range(0, 1));
    end else begin
      step = 64'(spacing_ns_cfg >> 2) + 64'($urandom) % (64'(spacing_ns_cfg >> 1) + 64'd1);
      p.start_ns = stream_ns + step;
    end
    stream_ns = p.start_ns;
    case ($urandom_range(0, 9))
      0:       elapsed = budget >> 1;
      1:       elapsed = (budget >> 1) + 64'd1;
      2:       elapsed = budget;
      3:       elapsed = budget - 64'(budget != 0);
      4:       elapsed = 64'd65_536_000 - 64'($urandom_range(0, 1000));
      5:       elapsed = {32'd0, $urandom};
      6:       elapsed = {$urandom, $urandom};
      default: elapsed = 64'($urandom) % (budget + (budget >> 1) + 64'd1);
    endcase
    p.end_ns = p.start_ns + elapsed;
    case ($urandom_range(0, 5))
      0:       p.dev_ns = budget << 1;
      1:       p.dev_ns = (budget << 1) + 64'd1;
      2:       p.dev_ns = {$urandom, $urandom};
      3:       p.dev_ns = -64'($urandom_range(0, 5000));
      default: p.dev_ns = 64'($urandom) % ((budget << 2) + 64'd1);
    endcase
    return p;
  endfunction

  function automatic logic [31:0] pick_frame_period();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'(ctm_pkg::FP_RESET);
      default: return $urandom_range(1, 1_000_000);
    endcase
  endfunction

  function automatic logic [31:0] pick_spacing();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return ctm_pkg::SPACING_RESET;
      3:       return $urandom_range(1, 64);
      default: return $urandom_range(1000, 20_000_000);
    endcase
  endfunction

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ctm_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      ctm_pkg::CFG_FRAME_PERIOD:   fp_ns_cfg      = data[19:0];
      ctm_pkg::CFG_SAMPLE_SPACING: spacing_ns_cfg = data;
      default: ;
    endcase
  endtask

  task automatic send_period(input period_t p, input logic typed, input report_t typed_want);
    int unsigned gap;
    report_t     predicted;
    gap = pick_gap();
    // keep valid high across back-to-back transactions
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i              <= 1'b1;
    start_time_ns_i         <= p.start_ns;
    end_time_ns_i           <= p.end_ns;
    frames_i                <= p.frames;
    interval_known_i        <= p.known;
    interval_deviation_ns_i <= p.dev_ns;
    interval_peak_ns_i      <= p.peak_ns;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = predict_period(p);
    expected_reports.push_back(typed ? typed_want : predicted);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      failed = 1'b1;
      $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Receiver side: stretches of stall and no stall, lengths from pick_gap.
  initial begin : receiver
    int unsigned hold;
    logic        stall_now;
    hold      = 0;
    stall_now = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold == 0) begin
        stall_now = !quiet && ($urandom_range(0, 2) == 0);
        hold      = pick_gap();
      end else begin
        hold--;
      end
      out_stall_i <= stall_now;
    end
  end

  always @(posedge clk_i) begin : result_check
    report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        failed = 1'b1;
        $display("%0t result: expected none, got elapsed %0h", $time, elapsed_ns_o);
      end else begin
        want = expected_reports.pop_front();
        check_field("sample_valid",    64'(want.sample_valid),    64'(sample_valid_o));
        check_field("budget_centipct", 64'(want.budget_centipct), 64'(budget_centipct_o));
        check_field("latency_us",      64'(want.latency_us),      64'(latency_us_o));
        check_field("sampled_peak_ns", 64'(want.sampled_peak_ns), 64'(sampled_peak_ns_o));
        check_field("delay_event",     64'(want.delay_event),     64'(delay_event_o));
        check_field("overrun_event",   64'(want.overrun_event),   64'(overrun_event_o));
        check_field("elapsed",         want.span_ns,              elapsed_ns_o);
        check_field("budget_out_ns",   64'(want.budget_out_ns),   64'(budget_out_ns_o));
        check_field("total_time_ns",   want.total_time_ns,        total_time_ns_o);
        check_field("worst_time_ns",   want.worst_time_ns,        worst_time_ns_o);
        check_field("overrun_total",   64'(want.overrun_total),   64'(overrun_total_o));
      end
    end
  end

  initial begin : stimulus
    row_t        rows[$];
    int unsigned phase;
    failed         = 1'b0;
    quiet          = 1'b0;
    fp_ns_cfg      = ctm_pkg::FP_RESET;
    spacing_ns_cfg = ctm_pkg::SPACING_RESET;
    last_sample_ns = '0;
    elapsed_sum_ns = '0;
    elapsed_max_ns = '0;
    overrun_count  = '0;
    stream_ns      = '0;
    rst_ni                  <= 1'b0;
    in_valid_i              <= 1'b0;
    start_time_ns_i         <= '0;
    end_time_ns_i           <= '0;
    frames_i                <= '0;
    interval_known_i        <= 1'b0;
    interval_deviation_ns_i <= '0;
    interval_peak_ns_i      <= '0;
    cfg_valid_i             <= 1'b0;
    cfg_index_i             <= '0;
    cfg_data_i              <= '0;

    // Reset defaults: nothing sampled yet, then the first sample, then the extremes.
    rows.push_back(checked_row(period_of(64'd0, 64'd0, 16'd0, 1'b0, 64'd0, 32'd0), '0));
    rows.push_back(checked_row(
      period_of(64'd10_000_000, 64'd10_020_833, 16'd1, 1'b1, 64'd41667, 32'hFFFF_FFFF),
      '{1'b1, 14'd10000, 16'd20, 32'hFFFF_FFFF, 1'b1, 1'b1,
        64'd20833, 36'd20833, 64'd20833, 64'd20833, 32'd1}));
    rows.push_back(checked_row(
      period_of(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 16'hFFFF, 1'b1, 64'h8000_0000_0000_0000, 32'd0),
      '{1'b1, 14'd0, 16'd0, 32'd0, 1'b0, 1'b0,
        64'd1, 36'd1365290655, 64'd20834, 64'd20833, 32'd1}));
    // timestamp wrap into a sample, one short of the spacing, latency saturation edge
    rows.push_back(item_row(
      period_of(64'd9_999_999, 64'd10_010_415, 16'd1, 1'b1, 64'd41666, 32'h1)));
    rows.push_back(item_row(
      period_of(64'd19_999_998, 64'd20_010_415, 16'd1, 1'b1, 64'd41667, 32'h2)));
    rows.push_back(item_row(
      period_of(64'd20_000_000, 64'd85_535_999, 16'd3000, 1'b0, '1, 32'd5)));
    rows.push_back(item_row(
      period_of(64'd40_000_000, 64'd105_536_000, 16'hFFFF, 1'b1,
                64'h7FFF_FFFF_FFFF_FFFF, 32'hAAAA_5555)));
    rows.push_back(item_row(
      period_of(64'd0, '1, 16'd2, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0)));
    // zero budget, every period sampled
    rows.push_back(reg_row(ctm_pkg::CFG_SAMPLE_SPACING, 32'd0));
    rows.push_back(item_row(period_of(64'd100, 64'd105, 16'd0, 1'b1, 64'd1, 32'h8000_0000)));
    rows.push_back(item_row(period_of(64'd200, 64'd200, 16'd0, 1'b1, 64'd0, 32'h7FFF_FFFF)));
    rows.push_back(reg_row(ctm_pkg::CFG_FRAME_PERIOD, 32'd0));
    rows.push_back(item_row(period_of(64'd300, 64'd301, 16'hFFFF, 1'b1, 64'd1, 32'h1234)));
    // widest budget: upper data bits drop off the frame period
    rows.push_back(reg_row(ctm_pkg::CFG_FRAME_PERIOD, 32'hFFFF_FFFF));
    rows.push_back(item_row(period_of(64'd400, 64'd400 + 64'hF_FFEF_0000, 16'hFFFF, 1'b0,
                                      64'h8000_0000_0000_0000, 32'd0)));
    rows.push_back(item_row(period_of(64'd500, 64'd500 + 64'hF_FFEF_0001, 16'hFFFF, 1'b1,
                                      64'h1_FFDE_0003, 32'hFFFF_FFFF)));
    rows.push_back(reg_row(CFG_UNMAPPED, 32'hFFFF_FFFF));
    rows.push_back(item_row(period_of(64'h1000, 64'h1000 + 64'h7_FFF7_8000, 16'hFFFF, 1'b1,
                                      64'h1_FFDE_0002, 32'd0)));
    rows.push_back(reg_row(ctm_pkg::CFG_SAMPLE_SPACING, 32'hFFFF_FFFF));
    rows.push_back(item_row(period_of(64'h1000 + 64'hFFFF_FFFE,
                                      64'h1000 + 64'hFFFF_FFFE + 64'h7_FFF7_8001,
                                      16'hFFFF, 1'b0, 64'd0, 32'd0)));
    rows.push_back(item_row(period_of(64'h1000 + 64'hFFFF_FFFF, 64'h1000 + 64'h1_0000_0000,
                                      16'hFFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 32'h5555_AAAA)));
    rows.push_back(reg_row(ctm_pkg::CFG_FRAME_PERIOD, 32'd1));
    rows.push_back(item_row(period_of(64'h2_0000_2000, 64'h2_0000_2000, 16'd1, 1'b0,
                                      64'd0, 32'd0)));
    rows.push_back(item_row(period_of(64'h3_0000_3000, 64'h3_0000_3001, 16'd1, 1'b1,
                                      64'd3, 32'd9)));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_REG: write_reg(rows[i].reg_idx, rows[i].reg_data);
        default: send_period(rows[i].period, rows[i].kind == ROW_CHECKED, rows[i].want);
      endcase
    end

    for (phase = 0; phase < PHASES; phase++) begin
      quiet = (phase % 4 == 2);
      case (phase)
        0: begin
          write_reg(ctm_pkg::CFG_FRAME_PERIOD, 32'hFFFF_FFFF);
          write_reg(ctm_pkg::CFG_SAMPLE_SPACING, 32'd0);
        end
        PHASES - 1: begin
          write_reg(ctm_pkg::CFG_FRAME_PERIOD, 32'd1);
          write_reg(ctm_pkg::CFG_SAMPLE_SPACING, 32'hFFFF_FFFF);
        end
        default: begin
          write_reg(ctm_pkg::CFG_FRAME_PERIOD, pick_frame_period());
          write_reg(ctm_pkg::CFG_SAMPLE_SPACING, pick_spacing());
        end
      endcase
      // run one phase across the 64-bit timestamp wrap
      if (phase == 5) stream_ns = '1 - 64'(spacing_ns_cfg) * 64'd40;
      repeat (PHASE_ITEMS) send_period(random_period(), 1'b0, '0);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (!failed) begin
      $display("callback_timing_monitor_unit: match");
    end else begin
      $display("callback_timing_monitor_unit: mismatch");
    end
    $finish;
  end

endmodule
